/* hdl/assert_macros.svh */
// Assertion macros for the naive Bayes classifier unit.
// Used by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define NBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NBC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define NBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define NBC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

/* hdl/nbc_pkg.sv */
// Shared types, codes and exp tables for the naive Bayes classifier unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nbc_pkg;

  localparam int USAGE_W = 12;
  localparam int CNT_W   = 13;
  localparam int SUM_W   = 24;
  localparam int SQ_W    = 36;

  localparam logic [CNT_W-1:0] CNT_MAX = 13'h1FFF;
  localparam logic [SUM_W:0]   SUM_MAX = 25'h0FF_FFFF;
  localparam logic [SQ_W:0]    SQ_MAX  = 37'h0F_FFFF_FFFF;

  // operation codes
  localparam logic [1:0] OP_LEARN    = 2'd0;
  localparam logic [1:0] OP_CLASSIFY = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_CLASSIFIED = 3'd0;
  localparam logic [2:0] STAT_LEARNED    = 3'd1;
  localparam logic [2:0] STAT_BAD        = 3'd2;
  localparam logic [2:0] STAT_NOT_READY  = 3'd3;
  localparam logic [2:0] STAT_FULL       = 3'd4;
  localparam logic [2:0] STAT_CLEARED    = 3'd5;

  // command kinds decided by the front end
  localparam logic [1:0] KIND_LEARN    = 2'd0;
  localparam logic [1:0] KIND_CLASSIFY = 2'd1;
  localparam logic [1:0] KIND_CLEAR    = 2'd2;
  localparam logic [1:0] KIND_BAD      = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         doc;
    logic               flag;
    logic [USAGE_W-1:0] usage;
    logic               label;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  // round(65536 * e^-k)
  function automatic logic [16:0] exp_k(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // round(65536 * e^(-j/16))
  function automatic logic [16:0] exp_f(input logic [3:0] j);
    logic [16:0] v;
    case (j)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/nbc_if.sv */
// Valid/ready channel interfaces for the classifier input and result items.
// Depends on nbc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface nbc_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [1:0]                  doc_type;
  logic                        cert_valid;
  logic [nbc_pkg::USAGE_W-1:0] usage_days;
  logic                        class_label;
  modport source(output valid, op, doc_type, cert_valid, usage_days, class_label,
                 input ready);
  modport sink(input valid, op, doc_type, cert_valid, usage_days, class_label,
               output ready);
endinterface

interface nbc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] post_class0;
  logic [15:0] post_class1;
  logic        predicted_class;
  logic [2:0]  status;
  modport source(output valid, post_class0, post_class1, predicted_class, status,
                 input ready);
  modport sink(input valid, post_class0, post_class1, predicted_class, status,
               output ready);
endinterface
`default_nettype wire

/* hdl/nbc_front.sv */
// Front end: accepts input items, checks features and decodes a command kind.
// Depends on nbc_pkg and nbc_if.
`timescale 1ns / 1ps
`default_nettype none
module nbc_front #(
  parameter int USAGE_BITS = 12
) (
  nbc_in_if.sink          in_ch,
  input  nbc_pkg::q_stat_t q_stat,
  output logic             push,
  output nbc_pkg::cmd_t    cmd
);

  logic usage_bad;
  logic feat_bad;

  // accept while the queue has room
  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  // flag out-of-range features
  assign usage_bad = 32'(in_ch.usage_days) > ((32'd1 << USAGE_BITS) - 32'd1);
  assign feat_bad  = usage_bad || (in_ch.doc_type == 2'd0);

  // decode kind
  always_comb begin
    cmd.doc   = in_ch.doc_type;
    cmd.flag  = in_ch.cert_valid;
    cmd.usage = in_ch.usage_days;
    cmd.label = in_ch.class_label;
    case (in_ch.op)
      nbc_pkg::OP_CLEAR:    cmd.kind = nbc_pkg::KIND_CLEAR;
      nbc_pkg::OP_LEARN:    cmd.kind = feat_bad ? nbc_pkg::KIND_BAD : nbc_pkg::KIND_LEARN;
      nbc_pkg::OP_CLASSIFY: cmd.kind = feat_bad ? nbc_pkg::KIND_BAD : nbc_pkg::KIND_CLASSIFY;
      default:              cmd.kind = nbc_pkg::KIND_BAD;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/nbc_queue.sv */
// Two-entry command queue between front end and back end.
// Depends on nbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nbc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  nbc_pkg::cmd_t    din,
  input  logic             pop,
  output nbc_pkg::cmd_t    dout,
  output nbc_pkg::q_stat_t q_stat
);

  nbc_pkg::cmd_t mem_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;

  assign dout         = mem_r[rp_r];
  assign q_stat.full  = cnt_r == 2'd2;
  assign q_stat.empty = cnt_r == 2'd0;

  // store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/nbc_div.sv */
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// Depends on nbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nbc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  nbc_pkg::div_req_t req,
  output nbc_pkg::div_rsp_t rsp
);

  logic [63:0] rem_r;
  logic [63:0] quo_r;
  logic [63:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] shifted;
  logic        fits;
  logic [64:0] rem_nxt;

  // one shift-subtract step
  assign shifted = {rem_r, quo_r[63]};
  assign fits    = shifted >= {1'b0, dvs_r};
  assign rem_nxt = fits ? (shifted - {1'b0, dvs_r}) : shifted;

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= 64'd0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
      cnt_r <= 6'd63;
    end else if (busy_r) begin
      rem_r <= rem_nxt[63:0];
      quo_r <= {quo_r[62:0], fits};
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/nbc_back.sv */
// Back end: holds the model, executes learn/clear, runs the classify sequence.
// Depends on nbc_pkg, nbc_if and the nbc_div unit it drives.
`timescale 1ns / 1ps
`default_nettype none
module nbc_back #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nbc_pkg::cmd_t     head,
  input  nbc_pkg::q_stat_t  q_stat,
  output logic              pop,
  output nbc_pkg::div_req_t div_req,
  input  nbc_pkg::div_rsp_t div_rsp,
  nbc_out_if.source         out_ch
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EMIT = 4'd1;
  localparam logic [3:0] ST_DWAIT = 4'd2;
  localparam logic [3:0] ST_PROD = 4'd3;
  localparam logic [3:0] ST_VAR = 4'd4;
  localparam logic [3:0] ST_MU = 4'd5;
  localparam logic [3:0] ST_DIFF = 4'd6;
  localparam logic [3:0] ST_D4 = 4'd7;
  localparam logic [3:0] ST_SQI = 4'd8;
  localparam logic [3:0] ST_SQRT = 4'd9;
  localparam logic [3:0] ST_EXP = 4'd10;
  localparam logic [3:0] ST_CF = 4'd11;
  localparam logic [3:0] ST_WDIV = 4'd12;
  localparam logic [3:0] ST_T = 4'd13;
  localparam logic [3:0] ST_SUM = 4'd14;
  localparam logic [3:0] ST_POST = 4'd15;

  // model state
  logic [nbc_pkg::CNT_W-1:0] cnt_r [2];
  logic [nbc_pkg::CNT_W-1:0] cat_r [6];
  logic [nbc_pkg::CNT_W-1:0] flg_r [4];
  logic [nbc_pkg::SUM_W-1:0] sum_r [2];
  logic [nbc_pkg::SQ_W-1:0]  sqs_r [2];

  // sequencer
  logic [3:0]    state_r;
  logic [3:0]    ret_r;
  logic          cls_r;
  logic          post_sel_r;
  nbc_pkg::cmd_t cmd_r;
  logic          dstart_r;
  logic [63:0]   dvd_r;
  logic [63:0]   dvs_r;

  // datapath registers
  logic [63:0] prod_a_r;
  logic [63:0] prod_b_r;
  logic [25:0] den_r;
  logic [63:0] var8_r [2];
  logic [63:0] d4_r [2];
  logic [15:0] sd_r [2];
  logic [16:0] e_r;
  logic [25:0] cf_r;
  logic [63:0] t_r [2];
  logic [63:0] sqx_r;
  logic [63:0] sqroot_r;
  logic [4:0]  sqi_r;

  // result and output registers
  logic [15:0] res_p0_r;
  logic [15:0] res_p1_r;
  logic        res_pr_r;
  logic [2:0]  res_st_r;
  logic        ov_r;
  logic [15:0] o_p0_r;
  logic [15:0] o_p1_r;
  logic        o_pr_r;
  logic [2:0]  o_st_r;

  // learn checks
  logic [13:0] total;
  logic [24:0] sum_new;
  logic [23:0] usage_sq;
  logic [36:0] sqs_new;
  logic        store_full;
  logic [2:0]  lcat_idx;
  logic [1:0]  lflg_idx;

  // classify helpers
  logic [nbc_pkg::CNT_W-1:0] n_cur;
  logic [63:0] m_val;
  logic [63:0] mu8;
  logic [63:0] v8;
  logic [63:0] diff;
  logic [63:0] sq_bit;
  logic [63:0] sq_rb;
  logic        sq_take;
  logic [63:0] sq_x_nxt;
  logic [63:0] sq_r_nxt;
  logic [63:0] d4_min;
  logic [63:0] dd;
  logic [34:0] e_raw;
  logic [2:0]  ccat_idx;
  logic [1:0]  cflg_idx;
  logic [64:0] t_sum;
  logic [15:0] q_sat;

  assign pop = (state_r == ST_IDLE) && !q_stat.empty;

  assign div_req.start    = dstart_r;
  assign div_req.dividend = dvd_r;
  assign div_req.divisor  = dvs_r;

  assign out_ch.valid           = ov_r;
  assign out_ch.post_class0     = o_p0_r;
  assign out_ch.post_class1     = o_p1_r;
  assign out_ch.predicted_class = o_pr_r;
  assign out_ch.status          = o_st_r;

  // learn bounds for the queue head
  assign total      = {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
  assign sum_new    = {1'b0, sum_r[head.label]} + 25'(head.usage);
  assign usage_sq   = 24'(head.usage) * 24'(head.usage);
  assign sqs_new    = {1'b0, sqs_r[head.label]} + 37'(usage_sq);
  assign store_full = (32'(total) >= 32'(MAX_SAMPLES)) ||
                      (cnt_r[head.label] == nbc_pkg::CNT_MAX) ||
                      (sum_new > nbc_pkg::SUM_MAX) || (sqs_new > nbc_pkg::SQ_MAX);
  assign lcat_idx   = (head.label ? 3'd3 : 3'd0) + {1'b0, head.doc} - 3'd1;
  assign lflg_idx   = {head.label, head.flag};

  // classify datapath for the current class
  assign n_cur    = cnt_r[cls_r];
  assign m_val    = (prod_a_r > prod_b_r) ? (prod_a_r - prod_b_r) : 64'd0;
  assign mu8      = div_rsp.quotient;
  assign v8       = {44'd0, cmd_r.usage, 8'd0};
  assign diff     = (v8 >= mu8) ? (v8 - mu8) : (mu8 - v8);
  assign sq_bit   = 64'd1 << {sqi_r, 1'b0};
  assign sq_rb    = sqroot_r + sq_bit;
  assign sq_take  = sqx_r >= sq_rb;
  assign sq_x_nxt = sq_take ? (sqx_r - sq_rb) : sqx_r;
  assign sq_r_nxt = sq_take ? ((sqroot_r >> 1) + sq_bit) : (sqroot_r >> 1);
  assign d4_min   = (d4_r[0] < d4_r[1]) ? d4_r[0] : d4_r[1];
  assign dd       = d4_r[cls_r] - d4_min;
  assign e_raw    = 35'(nbc_pkg::exp_k(dd[7:4])) * 35'(nbc_pkg::exp_f(dd[3:0])) + 35'd32768;
  assign ccat_idx = (cls_r ? 3'd3 : 3'd0) + {1'b0, cmd_r.doc} - 3'd1;
  assign cflg_idx = {cls_r, cmd_r.flag};
  assign t_sum    = {1'b0, t_r[0]} + {1'b0, t_r[1]};
  assign q_sat    = (div_rsp.quotient > 64'd65535) ? 16'hFFFF : div_rsp.quotient[15:0];

  // sequencer and model update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      dstart_r <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        cnt_r[i] <= '0;
        sum_r[i] <= '0;
        sqs_r[i] <= '0;
      end
      for (int i = 0; i < 6; i++) begin
        cat_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        flg_r[i] <= '0;
      end
    end else begin
      dstart_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            cmd_r    <= head;
            res_p0_r <= 16'd0;
            res_p1_r <= 16'd0;
            res_pr_r <= 1'b0;
            cls_r    <= 1'b0;
            state_r  <= ST_EMIT;
            case (head.kind)
              nbc_pkg::KIND_CLEAR: begin
                res_st_r <= nbc_pkg::STAT_CLEARED;
                for (int i = 0; i < 2; i++) begin
                  cnt_r[i] <= '0;
                  sum_r[i] <= '0;
                  sqs_r[i] <= '0;
                end
                for (int i = 0; i < 6; i++) begin
                  cat_r[i] <= '0;
                end
                for (int i = 0; i < 4; i++) begin
                  flg_r[i] <= '0;
                end
              end
              nbc_pkg::KIND_LEARN: begin
                if (store_full) begin
                  res_st_r <= nbc_pkg::STAT_FULL;
                end else begin
                  res_st_r              <= nbc_pkg::STAT_LEARNED;
                  cnt_r[head.label]     <= cnt_r[head.label] + 13'd1;
                  cat_r[lcat_idx]       <= cat_r[lcat_idx] + 13'd1;
                  flg_r[lflg_idx]       <= flg_r[lflg_idx] + 13'd1;
                  sum_r[head.label]     <= sum_new[23:0];
                  sqs_r[head.label]     <= sqs_new[35:0];
                end
              end
              nbc_pkg::KIND_CLASSIFY: begin
                if (cnt_r[0] < 13'd2 || cnt_r[1] < 13'd2) begin
                  res_st_r <= nbc_pkg::STAT_NOT_READY;
                end else begin
                  state_r <= ST_PROD;
                end
              end
              default: begin
                res_st_r <= nbc_pkg::STAT_BAD;
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (!ov_r || out_ch.ready) begin
            state_r <= ST_IDLE;
          end
        end
        ST_DWAIT: begin
          if (div_rsp.done) begin
            state_r <= ret_r;
          end
        end
        // n*Q, S*S and n*(n-1)
        ST_PROD: begin
          prod_a_r <= 64'(n_cur) * 64'(sqs_r[cls_r]);
          prod_b_r <= 64'(sum_r[cls_r]) * 64'(sum_r[cls_r]);
          den_r    <= 26'(n_cur) * 26'(n_cur - 13'd1);
          state_r  <= ST_VAR;
        end
        ST_VAR: begin
          dvd_r    <= {m_val[55:0], 8'd0};
          dvs_r    <= 64'(den_r);
          dstart_r <= 1'b1;
          ret_r    <= ST_MU;
          state_r  <= ST_DWAIT;
        end
        ST_MU: begin
          var8_r[cls_r] <= div_rsp.quotient;
          if (div_rsp.quotient == 64'd0) begin
            res_st_r <= nbc_pkg::STAT_NOT_READY;
            state_r  <= ST_EMIT;
          end else begin
            dvd_r    <= {32'd0, sum_r[cls_r], 8'd0};
            dvs_r    <= 64'(n_cur);
            dstart_r <= 1'b1;
            ret_r    <= ST_DIFF;
            state_r  <= ST_DWAIT;
          end
        end
        // mean is below 2^31 for n >= 2, so the difference fits 32 bits
        ST_DIFF: begin
          prod_a_r <= 64'(diff[31:0]) * 64'(diff[31:0]);
          state_r  <= ST_D4;
        end
        ST_D4: begin
          dvd_r    <= prod_a_r;
          dvs_r    <= {var8_r[cls_r][58:0], 5'd0};
          dstart_r <= 1'b1;
          ret_r    <= ST_SQI;
          state_r  <= ST_DWAIT;
        end
        ST_SQI: begin
          d4_r[cls_r] <= div_rsp.quotient;
          sqx_r       <= var8_r[cls_r];
          sqroot_r    <= 64'd0;
          sqi_r       <= 5'd31;
          state_r     <= ST_SQRT;
        end
        // integer square root, one result bit per cycle
        ST_SQRT: begin
          sqx_r    <= sq_x_nxt;
          sqroot_r <= sq_r_nxt;
          sqi_r    <= sqi_r - 5'd1;
          if (sqi_r == 5'd0) begin
            sd_r[cls_r] <= (sq_r_nxt > 64'd65535) ? 16'hFFFF : sq_r_nxt[15:0];
            cls_r       <= !cls_r;
            state_r     <= cls_r ? ST_EXP : ST_PROD;
          end
        end
        // exp of the exponent gap and category times flag count
        ST_EXP: begin
          e_r     <= (dd[63:4] < 60'd12) ? e_raw[32:16] : 17'd0;
          cf_r    <= 26'(cat_r[ccat_idx]) * 26'(flg_r[cflg_idx]);
          state_r <= ST_CF;
        end
        ST_CF: begin
          prod_a_r <= 64'(cf_r) * 64'(e_r);
          state_r  <= ST_WDIV;
        end
        ST_WDIV: begin
          dvd_r    <= prod_a_r;
          dvs_r    <= 64'(n_cur);
          dstart_r <= 1'b1;
          ret_r    <= ST_T;
          state_r  <= ST_DWAIT;
        end
        ST_T: begin
          t_r[cls_r] <= 64'(div_rsp.quotient[47:0]) * 64'(sd_r[!cls_r]);
          cls_r      <= !cls_r;
          state_r    <= cls_r ? ST_SUM : ST_EXP;
        end
        // scale both terms below 2^47, then divide for class 0
        ST_SUM: begin
          if (t_sum == 65'd0) begin
            res_st_r <= nbc_pkg::STAT_NOT_READY;
            state_r  <= ST_EMIT;
          end else if (t_sum[64:47] != 18'd0) begin
            t_r[0] <= t_r[0] >> 1;
            t_r[1] <= t_r[1] >> 1;
          end else begin
            dvd_r      <= {t_r[0][47:0], 16'd0};
            dvs_r      <= t_sum[63:0];
            dstart_r   <= 1'b1;
            post_sel_r <= 1'b0;
            ret_r      <= ST_POST;
            state_r    <= ST_DWAIT;
          end
        end
        ST_POST: begin
          if (!post_sel_r) begin
            res_p0_r   <= q_sat;
            dvd_r      <= {t_r[1][47:0], 16'd0};
            dstart_r   <= 1'b1;
            post_sel_r <= 1'b1;
            ret_r      <= ST_POST;
            state_r    <= ST_DWAIT;
          end else begin
            res_p1_r <= q_sat;
            res_pr_r <= q_sat > 16'd32768;
            res_st_r <= nbc_pkg::STAT_CLASSIFIED;
            state_r  <= ST_EMIT;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (state_r == ST_EMIT && (!ov_r || out_ch.ready)) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && (!ov_r || out_ch.ready)) begin
      o_p0_r <= res_p0_r;
      o_p1_r <= res_p1_r;
      o_pr_r <= res_pr_r;
      o_st_r <= res_st_r;
    end
  end

endmodule
`default_nettype wire

/* hdl/mixed_naive_bayes_classifier_unit.sv */
// Channel    Dir   Handshake     Payload
// in_ch      in    valid/ready   op, doc_type, cert_valid, usage_days, class_label
// out_ch     out   valid/ready   post_class0, post_class1, predicted_class, status
//
// Learn, clear and bad-feature items go straight from the idle state to the emit state in the back end.
// Classify makes ten passes through the shared
// one-bit-per-cycle 64-bit divider plus two 32-step square roots.
// Reset is synchronous and clears the model; no clearing pass is needed.
// A two-entry queue lets input items be taken while the back end works;
// a waiting result holds in the output register until taken.
// Depends on nbc_pkg, nbc_if, nbc_front, nbc_queue, nbc_div, nbc_back.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mixed_naive_bayes_classifier_unit #(
  parameter int MAX_SAMPLES = 4096,
  parameter int USAGE_BITS  = 12
) (
  input  wire         clk,
  input  wire         rst_n,
  nbc_in_if.sink      in_ch,
  nbc_out_if.source   out_ch
);

  logic              q_push;
  logic              q_pop;
  nbc_pkg::cmd_t     push_cmd;
  nbc_pkg::cmd_t     q_head;
  nbc_pkg::q_stat_t  q_stat;
  nbc_pkg::div_req_t div_req;
  nbc_pkg::div_rsp_t div_rsp;

  nbc_front #(
    .USAGE_BITS(USAGE_BITS)
  ) u_front (
    .in_ch (in_ch),
    .q_stat(q_stat),
    .push  (q_push),
    .cmd   (push_cmd)
  );

  nbc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_cmd),
    .pop   (q_pop),
    .dout  (q_head),
    .q_stat(q_stat)
  );

  nbc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  nbc_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .q_stat (q_stat),
    .pop    (q_pop),
    .div_req(div_req),
    .div_rsp(div_rsp),
    .out_ch (out_ch)
  );

  // checks
  `NBC_ASSERT(a_push_room, clk, rst_n, q_push |-> !q_stat.full, "push into full queue")
  `NBC_ASSERT(a_pop_data, clk, rst_n, q_pop |-> !q_stat.empty, "pop from empty queue")
  `NBC_ASSERT(a_err_zero, clk, rst_n, (out_ch.valid && out_ch.status != nbc_pkg::STAT_CLASSIFIED) |-> (out_ch.post_class0 == 16'd0 && out_ch.post_class1 == 16'd0 && !out_ch.predicted_class), "nonzero payload on error status")
  `NBC_ASSERT(a_pred, clk, rst_n, out_ch.valid |-> (out_ch.predicted_class == (out_ch.post_class1 > 16'd32768)), "prediction disagrees with posterior")

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the mixed naive Bayes classifier unit.
// Depends on nbc_pkg, nbc_if and the mixed_naive_bayes_classifier_unit RTL.
`timescale 1ns / 1ps
module testbench;

  localparam int MAX_SAMPLES = 4096;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int FILL_ITEMS = 60;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [1:0]  doc;
    logic        flag;
    logic [11:0] usage;
    logic        label;
  } sample_t;

  typedef struct {
    logic [15:0] p0;
    logic [15:0] p1;
    logic        pred;
    logic [2:0]  status;
  } verdict_t;

  typedef struct {
    sample_t    s;
    logic       typed;
    logic [2:0] status;
  } row_t;

  localparam logic [16:0] EXP_INT[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162,
                                         60, 22, 8, 3, 1};
  localparam logic [16:0] EXP_FRAC[16] = '{65536, 61565, 57835, 54331, 51039, 47947,
                                          45042, 42313, 39750, 37341, 35079, 32954,
                                          30957, 29081, 27319, 25664};

  logic clk;
  logic rst_n;
  int   cycles;
  int   errors;
  int   burst_left;

  nbc_in_if  in_ch();
  nbc_out_if out_ch();

  mixed_naive_bayes_classifier_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // model copy
  logic [12:0] cls_n[2];
  logic [12:0] cat_n[6];
  logic [12:0] flg_n[4];
  logic [23:0] u_sum[2];
  logic [35:0] u_sq[2];

  verdict_t pending_verdicts[$];

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic void clear_model();
    for (int i = 0; i < 2; i++) begin
      cls_n[i] = '0; u_sum[i] = '0; u_sq[i] = '0;
    end
    for (int i = 0; i < 6; i++) cat_n[i] = '0;
    for (int i = 0; i < 4; i++) flg_n[i] = '0;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Compute the verdict for one item and advance the model copy.
  function automatic verdict_t classify_or_train(input sample_t s);
    verdict_t    v;
    logic [63:0] d4[2];
    logic [63:0] sd[2];
    logic [63:0] t[2];
    logic [63:0] n, sm, nq, s2, m, var8, mu8, v8, diff, dmin, dd, e, cf, w, sum;
    int          ci;
    v = '{default: '0};
    if (s.op == nbc_pkg::OP_CLEAR) begin
      clear_model();
      v.status = nbc_pkg::STAT_CLEARED;
      return v;
    end
    if (s.op == OP_UNUSED || s.doc == 2'd0) begin
      v.status = nbc_pkg::STAT_BAD;
      return v;
    end
    if (s.op == nbc_pkg::OP_LEARN) begin
      if (64'(cls_n[0]) + cls_n[1] >= MAX_SAMPLES || cls_n[s.label] >= nbc_pkg::CNT_MAX ||
          64'(u_sum[s.label]) + s.usage > 64'(nbc_pkg::SUM_MAX) ||
          64'(u_sq[s.label]) + 64'(s.usage) * s.usage > 64'(nbc_pkg::SQ_MAX)) begin
        v.status = nbc_pkg::STAT_FULL;
        return v;
      end
      ci = int'(s.label) * 3 + int'(s.doc) - 1;
      cls_n[s.label]++;
      cat_n[ci]++;
      flg_n[int'(s.label) * 2 + int'(s.flag)]++;
      u_sum[s.label] += s.usage;
      u_sq[s.label] += 36'(s.usage) * s.usage;
      v.status = nbc_pkg::STAT_LEARNED;
      return v;
    end
    // classify
    if (cls_n[0] < 2 || cls_n[1] < 2) begin
      v.status = nbc_pkg::STAT_NOT_READY;
      return v;
    end
    for (int c = 0; c < 2; c++) begin
      n = cls_n[c];
      sm = u_sum[c];
      nq = n * u_sq[c];
      s2 = sm * sm;
      m = (nq > s2) ? nq - s2 : 64'd0;
      var8 = (m << 8) / (n * (n - 1));
      mu8 = (sm << 8) / n;
      v8 = 64'(s.usage) << 8;
      diff = (v8 >= mu8) ? v8 - mu8 : mu8 - v8;
      if (var8 == 0) begin
        v.status = nbc_pkg::STAT_NOT_READY;
        return v;
      end
      d4[c] = (diff * diff) / (32 * var8);
      sd[c] = isqrt64(var8);
      if (sd[c] > 65535) sd[c] = 65535;
    end
    dmin = (d4[0] < d4[1]) ? d4[0] : d4[1];
    for (int c = 0; c < 2; c++) begin
      dd = d4[c] - dmin;
      e = 0;
      if ((dd >> 4) < 12)
        e = (64'(EXP_INT[dd >> 4]) * EXP_FRAC[dd & 15] + 32768) >> 16;
      cf = 64'(cat_n[c * 3 + int'(s.doc) - 1]) * flg_n[c * 2 + int'(s.flag)];
      w = cf * e / cls_n[c];
      t[c] = w * sd[1 - c];
    end
    sum = t[0] + t[1];
    if (sum == 0) begin
      v.status = nbc_pkg::STAT_NOT_READY;
      return v;
    end
    // narrow until the normalization fits
    while (sum >= (64'd1 << 47)) begin
      t[0] = t[0] >> 1;
      t[1] = t[1] >> 1;
      sum = t[0] + t[1];
    end
    t[0] = (t[0] << 16) / sum;
    t[1] = (t[1] << 16) / sum;
    v.p0 = (t[0] > 65535) ? 16'hFFFF : t[0][15:0];
    v.p1 = (t[1] > 65535) ? 16'hFFFF : t[1][15:0];
    v.pred = (t[1] > 32768);
    v.status = nbc_pkg::STAT_CLASSIFIED;
    return v;
  endfunction

  // Drive one item, hold until taken, then at the end of a burst often open a gap.
  task automatic send_item(input sample_t s, input logic typed, input logic [2:0] st);
    verdict_t v;
    in_ch.valid = 1'b1;
    in_ch.op = s.op;
    in_ch.doc_type = s.doc;
    in_ch.cert_valid = s.flag;
    in_ch.usage_days = s.usage;
    in_ch.class_label = s.label;
    do @(posedge clk); while (!in_ch.ready);
    v = classify_or_train(s);
    if (typed) v = '{p0: 16'd0, p1: 16'd0, pred: 1'b0, status: st};
    pending_verdicts.insert(pending_verdicts.size(), v);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 14);
      if ($urandom_range(0, 9) < 7) begin
        in_ch.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic sample_t random_learn(input logic lab, input logic wide);
    sample_t s;
    s.op = nbc_pkg::OP_LEARN;
    s.label = lab;
    s.doc = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(1, 3)) : (lab ? 2'd3 : 2'd1);
    s.flag = ($urandom_range(0, 3) == 0) ? ~lab : lab;
    if (wide) s.usage = 12'($urandom_range(0, 4095));
    else s.usage = lab ? 12'($urandom_range(1500, 3500)) : 12'($urandom_range(200, 1200));
    return s;
  endfunction

  function automatic sample_t random_item();
    sample_t s;
    int      r;
    r = $urandom_range(0, 99);
    s = random_learn(1'($urandom_range(0, 1)), $urandom_range(0, 6) == 0);
    if (r >= 60 && r < 90) begin
      s.op = nbc_pkg::OP_CLASSIFY;
      s.doc = ($urandom_range(0, 19) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
      s.flag = 1'($urandom_range(0, 1));
      s.usage = 12'($urandom_range(0, 4095));
    end else if (r >= 90 && r < 95) begin
      s.op = OP_UNUSED;
      s.doc = 2'($urandom_range(0, 3));
    end else if (r >= 95 && r < 98) begin
      s.doc = 2'd0;
    end else if (r >= 98 && $urandom_range(0, 1) == 0) begin
      s.op = nbc_pkg::OP_CLEAR;
      s.doc = 2'($urandom_range(0, 3));
    end
    return s;
  endfunction

  // Stall the receiver in phases: always ready, mostly ready, mostly stalled.
  always @(negedge clk) begin
    case ((cycles / 2500) % 3)
      0:       out_ch.ready = 1'b1;
      1:       out_ch.ready = ($urandom_range(0, 3) != 0);
      default: out_ch.ready = ($urandom_range(0, 9) < 3);
    endcase
  end

  // Compare each taken result with the oldest expected verdict.
  always @(posedge clk) begin
    verdict_t w;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result p0=%0d p1=%0d pred=%0d status=%0d", $time,
                 out_ch.post_class0, out_ch.post_class1, out_ch.predicted_class,
                 out_ch.status);
        errors <= errors + 1;
      end else begin
        w = pending_verdicts.pop_front();
        if (out_ch.post_class0 !== w.p0 || out_ch.post_class1 !== w.p1 ||
            out_ch.predicted_class !== w.pred || out_ch.status !== w.status) begin
          $display("%0t: mismatch expected p0=%0d p1=%0d pred=%0d status=%0d", $time,
                   w.p0, w.p1, w.pred, w.status);
          $display("%0t:          actual   p0=%0d p1=%0d pred=%0d status=%0d", $time,
                   out_ch.post_class0, out_ch.post_class1, out_ch.predicted_class,
                   out_ch.status);
          errors <= errors + 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL mixed_naive_bayes_classifier_unit");
      $finish;
    end
  end

  initial begin
    row_t    rows[$];
    sample_t s;
    cycles = 0;
    errors = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.doc_type = '0;
    in_ch.cert_valid = 1'b0;
    in_ch.usage_days = '0;
    in_ch.class_label = 1'b0;
    out_ch.ready = 1'b0;
    clear_model();

    // directed table: typed status where it is plain, predictor otherwise
    rows = '{
      '{'{nbc_pkg::OP_CLASSIFY, 2'd1, 1'b0, 12'd0, 1'b0}, 1'b1, nbc_pkg::STAT_NOT_READY},
      '{'{nbc_pkg::OP_LEARN, 2'd0, 1'b1, 12'd5, 1'b1}, 1'b1, nbc_pkg::STAT_BAD},
      '{'{OP_UNUSED, 2'd3, 1'b1, 12'hFFF, 1'b1}, 1'b1, nbc_pkg::STAT_BAD},
      '{'{nbc_pkg::OP_LEARN, 2'd1, 1'b0, 12'd0, 1'b0}, 1'b1, nbc_pkg::STAT_LEARNED},
      '{'{nbc_pkg::OP_LEARN, 2'd2, 1'b1, 12'hFFF, 1'b0}, 1'b1, nbc_pkg::STAT_LEARNED},
      '{'{nbc_pkg::OP_LEARN, 2'd3, 1'b0, 12'd0, 1'b1}, 1'b1, nbc_pkg::STAT_LEARNED},
      '{'{nbc_pkg::OP_CLASSIFY, 2'd1, 1'b0, 12'd7, 1'b0}, 1'b1, nbc_pkg::STAT_NOT_READY},
      '{'{nbc_pkg::OP_LEARN, 2'd3, 1'b1, 12'hFFF, 1'b1}, 1'b1, nbc_pkg::STAT_LEARNED},
      '{'{nbc_pkg::OP_CLASSIFY, 2'd1, 1'b0, 12'd0, 1'b1}, 1'b0, 3'd0},
      '{'{nbc_pkg::OP_CLASSIFY, 2'd3, 1'b1, 12'hFFF, 1'b0}, 1'b0, 3'd0},
      '{'{nbc_pkg::OP_CLASSIFY, 2'd0, 1'b1, 12'd100, 1'b0}, 1'b1, nbc_pkg::STAT_BAD},
      '{'{nbc_pkg::OP_CLEAR, 2'd0, 1'b1, 12'hFFF, 1'b1}, 1'b1, nbc_pkg::STAT_CLEARED},
      // zero variance in class 0
      '{'{nbc_pkg::OP_LEARN, 2'd1, 1'b1, 12'd50, 1'b0}, 1'b1, nbc_pkg::STAT_LEARNED},
      '{'{nbc_pkg::OP_LEARN, 2'd1, 1'b1, 12'd50, 1'b0}, 1'b1, nbc_pkg::STAT_LEARNED},
      '{'{nbc_pkg::OP_LEARN, 2'd1, 1'b0, 12'd10, 1'b1}, 1'b1, nbc_pkg::STAT_LEARNED},
      '{'{nbc_pkg::OP_LEARN, 2'd1, 1'b0, 12'd90, 1'b1}, 1'b1, nbc_pkg::STAT_LEARNED},
      '{'{nbc_pkg::OP_CLASSIFY, 2'd1, 1'b0, 12'd50, 1'b0}, 1'b1, nbc_pkg::STAT_NOT_READY},
      // category never seen in either class: zero denominator
      '{'{nbc_pkg::OP_LEARN, 2'd1, 1'b1, 12'd70, 1'b0}, 1'b1, nbc_pkg::STAT_LEARNED},
      '{'{nbc_pkg::OP_CLASSIFY, 2'd2, 1'b0, 12'd60, 1'b0}, 1'b1, nbc_pkg::STAT_NOT_READY},
      '{'{nbc_pkg::OP_CLASSIFY, 2'd1, 1'b1, 12'd55, 1'b0}, 1'b0, 3'd0},
      '{'{nbc_pkg::OP_CLASSIFY, 2'd1, 1'b0, 12'hFFF, 1'b1}, 1'b0, 3'd0},
      '{'{nbc_pkg::OP_CLEAR, 2'd1, 1'b0, 12'd0, 1'b0}, 1'b1, nbc_pkg::STAT_CLEARED}
    };

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_item(rows[i].s, rows[i].typed, rows[i].status);

    // random mix, mostly well-formed training with classify in between
    for (int i = 0; i < RANDOM_ITEMS; i++) send_item(random_item(), 1'b0, 3'd0);

    // retrain from a cleared model, classify it, then clear
    s.op = nbc_pkg::OP_CLEAR;
    s.doc = 2'd1; s.flag = 1'b0; s.usage = '0; s.label = 1'b0;
    send_item(s, 1'b1, nbc_pkg::STAT_CLEARED);
    for (int i = 0; i < FILL_ITEMS; i++)
      send_item(random_learn(1'(i), $urandom_range(0, 3) == 0), 1'b0, 3'd0);
    s = random_item();
    s.op = nbc_pkg::OP_CLASSIFY;
    s.doc = 2'($urandom_range(1, 3));
    send_item(s, 1'b0, 3'd0);
    s.op = nbc_pkg::OP_CLEAR;
    send_item(s, 1'b1, nbc_pkg::STAT_CLEARED);
    in_ch.valid = 1'b0;

    // drain, then give the back end time to show any stray result
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (errors == 0) begin
      $display("PASS mixed_naive_bayes_classifier_unit");
    end else begin
      $display("FAIL mixed_naive_bayes_classifier_unit");
    end
    $finish;
  end

endmodule

/* mixed_naive_bayes_classifier_unit.f */
+incdir+hdl
hdl/nbc_pkg.sv
hdl/nbc_if.sv
hdl/nbc_front.sv
hdl/nbc_queue.sv
hdl/nbc_div.sv
hdl/nbc_back.sv
hdl/mixed_naive_bayes_classifier_unit.sv
tb/testbench.sv
